// ===== rtl/s88fcd_pkg.sv =====
package s88fcd_pkg;

    localparam int MAX_MODULES_DEF = 32;
    localparam int NUM_CHAINS_DEF  = 4;

    // Limits that fix the packed widths shared between modules.
    localparam int CHAIN_LIMIT = 4;
    localparam int ROW_W_LIMIT = 9;

    localparam int ADDR_W      = 11;
    localparam int STATUS_W    = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam logic CMD_START  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // Data line of each chain in the raw status byte; chain one is inverted.
    localparam logic [STATUS_W-1:0] LINE_MASK [CHAIN_LIMIT] = '{8'h40, 8'h80, 8'h20, 8'h10};
    localparam logic [CHAIN_LIMIT-1:0] LINE_INVERT = 4'b0010;

    typedef struct packed {
        logic                command;
        logic [STATUS_W-1:0] status_byte;
    } t_in_item;

    typedef struct packed {
        logic [ADDR_W-1:0] feedback_address;
        logic              feedback_state;
        logic              last_event;
    } t_out_item;

    // One sample after classification: store row, chains to compare, new bits.
    typedef struct packed {
        logic [ROW_W_LIMIT-1:0] row;
        logic [CHAIN_LIMIT-1:0] active;
        logic [CHAIN_LIMIT-1:0] bits;
    } t_work;

endpackage

// ===== rtl/s88fcd_front.sv =====
module s88fcd_front #(
    parameter int MAX_MODULES = s88fcd_pkg::MAX_MODULES_DEF,
    parameter int NUM_CHAINS  = s88fcd_pkg::NUM_CHAINS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    input  s88fcd_pkg::t_in_item              i_in,
    output logic                              o_full,
    input  logic                              i_queue_full,
    input  logic                              i_clearing,
    output logic                              o_work_push,
    output s88fcd_pkg::t_work                 o_work,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [s88fcd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [s88fcd_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CL = s88fcd_pkg::CHAIN_LIMIT;

    localparam logic [s88fcd_pkg::CFG_IDX_W-1:0] REG_BUS_COUNT = 3'd0;
    localparam logic [s88fcd_pkg::CFG_IDX_W-1:0] REG_MODULES_0 = 3'd1;
    localparam logic [s88fcd_pkg::CFG_IDX_W-1:0] REG_MODULES_1 = 3'd2;
    localparam logic [s88fcd_pkg::CFG_IDX_W-1:0] REG_MODULES_2 = 3'd3;
    localparam logic [s88fcd_pkg::CFG_IDX_W-1:0] REG_MODULES_3 = 3'd4;
    localparam logic [s88fcd_pkg::CFG_IDX_W-1:0] REG_POLLING   = 3'd5;

    logic [2:0] r_bus_count;
    logic [5:0] r_modules [CL];
    logic       r_polling;
    logic [5:0] r_module_pos;
    logic [2:0] r_bit_pos;
    logic       r_scan_open;

    logic [5:0] n_module_pos;
    logic [2:0] n_bit_pos;
    logic       n_scan_open;

    logic [2:0]    chains;
    logic [6:0]    clamp [CL];
    logic [6:0]    scan_len;
    logic [6:0]    pos_ext;
    logic          in_scan;
    logic          accept;
    logic          take_sample;
    logic [CL-1:0] active;
    logic [CL-1:0] bits;

    assign o_cfg_ready = 1'b1;
    assign o_full      = i_queue_full || i_clearing;
    assign accept      = i_push && !o_full;
    assign pos_ext     = {1'b0, r_module_pos};

    always_comb begin
        chains = (r_bus_count > 3'(NUM_CHAINS)) ? 3'(NUM_CHAINS) : r_bus_count;
        for (int c = 0; c < CL; c++) begin
            clamp[c] = ({1'b0, r_modules[c]} > 7'(MAX_MODULES)) ? 7'(MAX_MODULES)
                                                                : {1'b0, r_modules[c]};
            bits[c]  = ((i_in.status_byte & s88fcd_pkg::LINE_MASK[c]) != '0)
                       ^ s88fcd_pkg::LINE_INVERT[c];
            active[c] = (c < NUM_CHAINS) && (3'(c) < chains) && (pos_ext < clamp[c]);
        end
        // With no chain compared the scan still runs over the full chain length.
        if (chains == 3'd0) begin
            scan_len = 7'(MAX_MODULES);
        end else begin
            scan_len = 7'd0;
            for (int c = 0; c < CL; c++) begin
                if ((c < NUM_CHAINS) && (3'(c) < chains) && (clamp[c] > scan_len)) begin
                    scan_len = clamp[c];
                end
            end
        end
        in_scan = r_scan_open && (pos_ext < scan_len);
    end

    assign take_sample = accept && r_polling && (i_in.command == s88fcd_pkg::CMD_SAMPLE)
                         && in_scan;
    assign o_work_push = take_sample && (active != '0);

    always_comb begin
        o_work.row    = s88fcd_pkg::ROW_W_LIMIT'({r_module_pos, r_bit_pos});
        o_work.active = active;
        o_work.bits   = bits;
    end

    always_comb begin
        n_module_pos = r_module_pos;
        n_bit_pos    = r_bit_pos;
        n_scan_open  = r_scan_open;
        if (accept && r_polling && (i_in.command == s88fcd_pkg::CMD_START)) begin
            n_module_pos = '0;
            n_bit_pos    = '0;
            n_scan_open  = 1'b1;
        end else if (take_sample) begin
            if (r_bit_pos == 3'd7) begin
                n_bit_pos = '0;
                if ((pos_ext + 7'd1) >= scan_len) begin
                    n_scan_open = 1'b0;
                end else begin
                    n_module_pos = r_module_pos + 6'd1;
                end
            end else begin
                n_bit_pos = r_bit_pos + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus_count  <= '0;
            r_polling    <= 1'b1;
            r_module_pos <= '0;
            r_bit_pos    <= '0;
            r_scan_open  <= 1'b0;
            for (int c = 0; c < CL; c++) begin
                r_modules[c] <= '0;
            end
        end else begin
            r_module_pos <= n_module_pos;
            r_bit_pos    <= n_bit_pos;
            r_scan_open  <= n_scan_open;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_BUS_COUNT: r_bus_count  <= i_cfg_data[2:0];
                    REG_MODULES_0: r_modules[0] <= i_cfg_data[5:0];
                    REG_MODULES_1: r_modules[1] <= i_cfg_data[5:0];
                    REG_MODULES_2: r_modules[2] <= i_cfg_data[5:0];
                    REG_MODULES_3: r_modules[3] <= i_cfg_data[5:0];
                    REG_POLLING:   r_polling    <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== rtl/s88fcd_queue.sv =====
module s88fcd_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  s88fcd_pkg::t_work  i_data,
    output logic               o_full,
    output logic               o_valid,
    input  logic               i_pop,
    output s88fcd_pkg::t_work  o_data
);

    localparam int DEPTH = s88fcd_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    s88fcd_pkg::t_work r_slot [DEPTH];
    logic [PW-1:0]     r_wr_ptr;
    logic [PW-1:0]     r_rd_ptr;
    logic [PW:0]       r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == (PW+1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== rtl/s88fcd_back.sv =====
module s88fcd_back #(
    parameter int MAX_MODULES = s88fcd_pkg::MAX_MODULES_DEF,
    parameter int NUM_CHAINS  = s88fcd_pkg::NUM_CHAINS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_work_valid,
    input  s88fcd_pkg::t_work     i_work,
    output logic                  o_work_pop,
    output logic                  o_clearing,
    input  logic                  i_pop,
    output logic                  o_empty,
    output s88fcd_pkg::t_out_item o_out
);

    localparam int ROWS   = MAX_MODULES * 8;
    localparam int RW     = $clog2(ROWS);
    localparam int NC     = NUM_CHAINS;
    localparam int CW     = (NC > 1) ? $clog2(NC) : 1;
    localparam int CALC_W = s88fcd_pkg::ADDR_W + 1;

    // One row per shift position, one bit per chain.
    logic [NC-1:0] r_mem [ROWS];

    logic          r_clearing;
    logic [RW-1:0] r_clr_addr;

    logic          r_rd_valid;
    logic [RW-1:0] r_rd_row;
    logic [NC-1:0] r_rd_active;
    logic [NC-1:0] r_rd_bits;
    logic [NC-1:0] r_rdata;

    logic          r_wb_valid;
    logic [RW-1:0] r_wb_row;
    logic [NC-1:0] r_wb_data;

    logic [NC-1:0] r_ev_mask;
    logic [NC-1:0] r_ev_bits;
    logic [RW-1:0] r_ev_row;

    logic                  r_out_valid;
    s88fcd_pkg::t_out_item r_out;

    logic [NC-1:0]     old_row;
    logic [NC-1:0]     change;
    logic [NC-1:0]     new_row;
    logic [NC-1:0]     rest;
    logic [CW-1:0]     sel;
    logic [CALC_W-1:0] addr_calc;
    logic              out_can_load;
    logic              ev_emit;
    logic              ev_free;
    logic              s2_adv;
    logic              s1_free;

    // A row written in the same cycle as its read was issued comes from the
    // write-back register, since the memory returns the old contents then.
    assign old_row = (r_wb_valid && (r_wb_row == r_rd_row)) ? r_wb_data : r_rdata;
    assign change  = r_rd_active & (old_row ^ r_rd_bits);
    assign new_row = (old_row & ~r_rd_active) | (r_rd_bits & r_rd_active);

    always_comb begin
        sel = '0;
        for (int c = NC - 1; c >= 0; c--) begin
            if (r_ev_mask[c]) begin
                sel = CW'(c);
            end
        end
    end

    assign rest      = r_ev_mask & (r_ev_mask - 1'b1);
    assign addr_calc = CALC_W'(sel) * CALC_W'(ROWS) + CALC_W'(r_ev_row) + CALC_W'(1);

    assign out_can_load = !r_out_valid || i_pop;
    assign ev_emit      = (r_ev_mask != '0) && out_can_load;
    assign ev_free      = (r_ev_mask == '0) || (ev_emit && (rest == '0));
    assign s2_adv       = r_rd_valid && ev_free;
    assign s1_free      = !r_rd_valid || s2_adv;
    assign o_work_pop   = i_work_valid && s1_free && !r_clearing;

    assign o_clearing = r_clearing;
    assign o_empty    = !r_out_valid;
    assign o_out      = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_rd_valid  <= 1'b0;
            r_wb_valid  <= 1'b0;
            r_ev_mask   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clearing) begin
                if (r_clr_addr == RW'(ROWS - 1)) begin
                    r_clearing <= 1'b0;
                end
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (o_work_pop) begin
                r_rd_valid <= 1'b1;
            end else if (s2_adv) begin
                r_rd_valid <= 1'b0;
            end
            if (s2_adv) begin
                r_wb_valid <= 1'b1;
                r_ev_mask  <= change;
            end else if (ev_emit) begin
                r_ev_mask <= rest;
            end
            if (ev_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_work_pop) begin
            r_rd_row    <= i_work.row[RW-1:0];
            r_rd_active <= i_work.active[NC-1:0];
            r_rd_bits   <= i_work.bits[NC-1:0];
        end
        if (s2_adv) begin
            r_wb_row  <= r_rd_row;
            r_wb_data <= new_row;
            r_ev_bits <= r_rd_bits;
            r_ev_row  <= r_rd_row;
        end
        if (ev_emit) begin
            r_out.feedback_address <= addr_calc[s88fcd_pkg::ADDR_W-1:0];
            r_out.feedback_state   <= r_ev_bits[sel];
            r_out.last_event       <= (rest == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= '0;
        end else if (s2_adv) begin
            r_mem[r_rd_row] <= new_row;
        end
        if (o_work_pop) begin
            r_rdata <= r_mem[i_work.row[RW-1:0]];
        end
    end

endmodule

// ===== rtl/s88_feedback_change_detector.sv =====
// S88 occupancy feedback change detector.
// Input queue side: present a word on i_in and raise push; it is taken at a
// clock edge where push is high and full is low. A start word opens a scan,
// each sample word carries the raw port status after one shift clock.
// Result queue side: while empty is low, o_out holds the oldest event (contact
// address, new state, and a flag on the last event of its sample); pop takes it.
// Configuration: i_cfg_valid with i_cfg_index and i_cfg_data writes a register;
// o_cfg_ready is always high. Write only while the block is idle.
// Throughput: one word per cycle while samples cause no change; a sample with
// k changed contacts gives k events, one event per cycle while results are
// popped, and holds the event stage until its last event leaves. A two-entry
// queue between the classifier and the compare stage lets the input run on
// while events drain.
// Reset: the control registers return to defaults, then the contact store is
// cleared one row a cycle, all MAX_MODULES*8 rows, with full held high meanwhile.
// A stalled result holds on o_out; once the internal stages fill, full rises.
module s88_feedback_change_detector #(
    parameter int MAX_MODULES = s88fcd_pkg::MAX_MODULES_DEF,
    parameter int NUM_CHAINS  = s88fcd_pkg::NUM_CHAINS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  s88fcd_pkg::t_in_item              i_in,
    output logic                              empty,
    input  logic                              pop,
    output s88fcd_pkg::t_out_item             o_out,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [s88fcd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [s88fcd_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic              queue_full;
    logic              queue_valid;
    logic              clearing;
    logic              work_push;
    logic              work_pop;
    s88fcd_pkg::t_work work_in;
    s88fcd_pkg::t_work work_out;

    s88fcd_front #(
        .MAX_MODULES(MAX_MODULES),
        .NUM_CHAINS (NUM_CHAINS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_in        (i_in),
        .o_full      (full),
        .i_queue_full(queue_full),
        .i_clearing  (clearing),
        .o_work_push (work_push),
        .o_work      (work_in),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    s88fcd_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (work_push),
        .i_data (work_in),
        .o_full (queue_full),
        .o_valid(queue_valid),
        .i_pop  (work_pop),
        .o_data (work_out)
    );

    s88fcd_back #(
        .MAX_MODULES(MAX_MODULES),
        .NUM_CHAINS (NUM_CHAINS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_work_valid(queue_valid),
        .i_work      (work_out),
        .o_work_pop  (work_pop),
        .o_clearing  (clearing),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_out       (o_out)
    );

endmodule

// ===== rtl/s88fcd_checker.sv =====
module s88fcd_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  full,
    input logic                  empty,
    input logic                  pop,
    input s88fcd_pkg::t_out_item o_out
);

    // Reset starts the store clearing pass, so input is refused right after.
    a_full_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> full)
        else $error("full low right after reset");

    a_empty_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result present right after reset");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out)))
        else $error("stalled result changed");

    // Events of one sample are delivered without gaps up to the last one.
    a_sample_events_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && !o_out.last_event) |=> !empty)
        else $error("gap inside the events of one sample");

endmodule

bind s88_feedback_change_detector s88fcd_checker u_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .full   (full),
    .empty  (empty),
    .pop    (pop),
    .o_out  (o_out)
);
